@@ rtl/fiv_pkg.sv @@
`timescale 1ns / 1ps

package fiv_pkg;

  // Reflected CRC-32 constants
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Bytes 0..7 carry the initial stack pointer and the reset handler
  localparam int unsigned VEC_BYTES = 8;
  localparam int unsigned REGION_W  = 24;

  // Register reset values
  localparam logic [31:0]         RST_EXPECTED_CRC = 32'h0000_0000;
  localparam logic [REGION_W-1:0] RST_REGION_SIZE  = 24'd393216;
  localparam logic [31:0]         RST_SRAM_BASE    = 32'h2000_0000;
  localparam logic [31:0]         RST_SRAM_END     = 32'h2001_FFFF;
  localparam logic [31:0]         RST_APP_BASE     = 32'h0802_0000;

  typedef enum logic [2:0] {
    CFG_EXPECTED_CRC,
    CFG_REGION_SIZE,
    CFG_SRAM_BASE,
    CFG_SRAM_END,
    CFG_APP_BASE
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_SIZE,
    ST_BAD_STACK,
    ST_NO_THUMB,
    ST_BAD_HANDLER,
    ST_BAD_CRC
  } status_e;

  typedef struct packed {
    logic [31:0]         expected_crc;
    logic [REGION_W-1:0] region_size;
    logic [31:0]         sram_base;
    logic [31:0]         sram_end;
    logic [31:0]         app_base;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic        image_ok;
    status_e     status;
    logic [31:0] crc_result;
  } out_item_t;

endpackage

@@ rtl/fiv_crc8.sv @@
`timescale 1ns / 1ps

module fiv_crc8 (
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);
  import fiv_pkg::*;

  // Eight bit steps of the reflected LFSR, folded into one xor network
  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'h0, byte_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

@@ rtl/fiv_check.sv @@
`timescale 1ns / 1ps

module fiv_check #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  fiv_pkg::cfg_t          cfg_i,
  input  logic [COUNT_BITS-1:0]  count_i,
  input  logic [31:0]            stack_i,
  input  logic [31:0]            handler_i,
  input  logic [31:0]            crc_i,
  output fiv_pkg::status_e       status_o
);
  import fiv_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > REGION_W) ? COUNT_BITS : REGION_W;

  logic        size_bad;
  logic        stack_bad;
  logic [31:0] handler_even;
  logic [32:0] region_lim;
  logic        handler_bad;

  // Saturated or zero count always fails, as does anything over the region size
  assign size_bad = (count_i == '1) || (count_i == '0) ||
                    (CMP_W'(count_i) > CMP_W'(cfg_i.region_size));

  assign stack_bad = (count_i < COUNT_BITS'(VEC_BYTES)) ||
                     (stack_i < cfg_i.sram_base) || (stack_i > cfg_i.sram_end);

  // Region end taken at 33 bits so it never wraps
  assign handler_even = {handler_i[31:1], 1'b0};
  assign region_lim   = {1'b0, cfg_i.app_base} + 33'(cfg_i.region_size);
  assign handler_bad  = (handler_even < cfg_i.app_base) ||
                        ({1'b0, handler_even} >= region_lim);

  always_comb begin
    if (size_bad) begin
      status_o = ST_BAD_SIZE;
    end else if (stack_bad) begin
      status_o = ST_BAD_STACK;
    end else if (!handler_i[0]) begin
      status_o = ST_NO_THUMB;
    end else if (handler_bad) begin
      status_o = ST_BAD_HANDLER;
    end else if (crc_i != cfg_i.expected_crc) begin
      status_o = ST_BAD_CRC;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

@@ rtl/firmware_image_verifier.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                | Beat
// ---------+-----------+--------------------------+------------------------------------
// in       | in        | in_valid_i / in_ready_o  | in_data_i: data_byte, is_last
// out      | out       | out_valid_o / out_ready_i| out_data_o: image_ok, status, crc
// cfg      | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while no final byte waits on a full result register. A verdict
// is loaded into the result register when the final byte leaves the input stage, so it
// reaches out_valid_o only after passing the input stage and then the result register.
// The input stage stalls only when it holds a final byte and the result register
// is still full and not being taken; non-final bytes never wait on out_ready_i.
// Reset presets the CRC to all ones, clears count and vector words and loads register defaults.
// The cfg port is always ready.

module firmware_image_verifier #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fiv_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fiv_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import fiv_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  // Input stage
  logic     stg_valid_q;
  in_item_t stg_q;
  logic     stg_adv;

  // Running image state
  logic [31:0]           crc_q, crc_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [31:0]           stack_q, stack_d;
  logic [31:0]           handler_q, handler_d;
  logic                  in_vec;
  logic [2:0]            lane;

  // Result register
  logic      out_valid_q;
  out_item_t out_q;
  status_e   status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_crc <= RST_EXPECTED_CRC;
      cfg_q.region_size  <= RST_REGION_SIZE;
      cfg_q.sram_base    <= RST_SRAM_BASE;
      cfg_q.sram_end     <= RST_SRAM_END;
      cfg_q.app_base     <= RST_APP_BASE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EXPECTED_CRC: cfg_q.expected_crc <= cfg_data_i;
        CFG_REGION_SIZE:  cfg_q.region_size  <= cfg_data_i[REGION_W-1:0];
        CFG_SRAM_BASE:    cfg_q.sram_base    <= cfg_data_i;
        CFG_SRAM_END:     cfg_q.sram_end     <= cfg_data_i;
        CFG_APP_BASE:     cfg_q.app_base     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A final byte may only leave the stage if the result slot is free or draining
  assign stg_adv    = stg_valid_q && (!stg_q.is_last || !out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || stg_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_q <= in_data_i;
    end
  end

  fiv_crc8 u_crc (
    .crc_i  (crc_q),
    .byte_i (stg_q.data_byte),
    .crc_o  (crc_d)
  );

  // Count before this byte picks the vector lane
  assign lane   = cnt_q[2:0];
  assign in_vec = (cnt_q[COUNT_BITS-1:3] == '0);

  always_comb begin
    cnt_d     = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
    stack_d   = stack_q;
    handler_d = handler_q;
    for (int k = 0; k < 4; k++) begin
      if (in_vec && lane == 3'(k)) begin
        stack_d[8*k +: 8] = stack_q[8*k +: 8] | stg_q.data_byte;
      end
      if (in_vec && lane == 3'(k + 4)) begin
        handler_d[8*k +: 8] = handler_q[8*k +: 8] | stg_q.data_byte;
      end
    end
  end

  fiv_check #(
    .COUNT_BITS (COUNT_BITS)
  ) u_check (
    .cfg_i     (cfg_q),
    .count_i   (cnt_d),
    .stack_i   (stack_d),
    .handler_i (handler_d),
    .crc_i     (crc_d ^ CRC_ONES),
    .status_o  (status)
  );

  // Image state returns to its reset value after each verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CRC_ONES;
      cnt_q     <= '0;
      stack_q   <= '0;
      handler_q <= '0;
    end else if (stg_adv) begin
      if (stg_q.is_last) begin
        crc_q     <= CRC_ONES;
        cnt_q     <= '0;
        stack_q   <= '0;
        handler_q <= '0;
      end else begin
        crc_q     <= crc_d;
        cnt_q     <= cnt_d;
        stack_q   <= stack_d;
        handler_q <= handler_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv && stg_q.is_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv && stg_q.is_last) begin
      out_q.image_ok   <= (status == ST_OK);
      out_q.status     <= status;
      out_q.crc_result <= crc_d ^ CRC_ONES;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_verdict_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_adv && stg_q.is_last |=> out_valid_q)
    else $error("verdict beat did not reach the result register");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_adv && stg_q.is_last |=> (cnt_q == '0) && (crc_q == CRC_ONES))
    else $error("image state not cleared after verdict");

  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.image_ok == (out_q.status == ST_OK)))
    else $error("image_ok disagrees with status");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stg_valid_q && stg_q.is_last && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked verdict");

endmodule

@@ tb/sv/tb_firmware_image_verifier.sv @@
`timescale 1ns / 1ps

module tb_firmware_image_verifier;
  import fiv_pkg::*;

  localparam int unsigned COUNT_BITS   = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int unsigned STREAM_BYTES = 900;    // the last batch may overshoot this total
  localparam int unsigned QUIET_BYTES  = 820;    // no idling past this point
  localparam int unsigned DRAIN_CYCLES = 4;      // settling time after the last owed verdict is taken
  localparam int unsigned END_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Indexes above the last register are decoded as no-ops
  localparam logic [2:0] CFG_SPARE_LO = 3'(CFG_APP_BASE) + 3'd1;
  localparam logic [2:0] CFG_SPARE_HI = '1;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_e;

  typedef enum int unsigned {
    IMG_GOOD, IMG_NO_THUMB, IMG_BAD_HANDLER, IMG_BAD_STACK, IMG_SHORT, IMG_NOISE
  } img_shape_e;

  // One line of the directed table: a register write or an input beat, the
  // final beat optionally carrying a hand-written verdict
  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] wdata;
    in_item_t    beat;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  logic      clk;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  firmware_image_verifier #(
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the verifier: register copy plus running image state
  // ---------------------------------------------------------------------------
  cfg_t                  model_cfg;
  logic [31:0]           crc_run;
  logic [COUNT_BITS-1:0] count_run;
  logic [31:0]           sp_word;
  logic [31:0]           hv_word;

  out_item_t   verdict_q[$];     // verdicts owed by the block, oldest first
  out_item_t   head_verdict;
  logic [7:0]  image_bytes[$];   // image being built for the random part
  dir_row_t    plan[$];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  bit          bursts_on;

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_image_state();
    crc_run   = CRC_ONES;
    count_run = '0;
    sp_word   = '0;
    hv_word   = '0;
  endfunction

  // Absorbs one beat; on the final byte returns 1 and the verdict
  function automatic bit image_verdict_step(input in_item_t beat, output out_item_t verdict);
    int unsigned pos;
    logic [31:0] crc_final;
    logic [31:0] h;
    logic [32:0] h_limit;
    status_e     st;
    bit          sat;
    pos = int'(count_run);
    if (pos < 4) begin
      sp_word |= 32'(beat.data_byte) << (8 * pos);
    end else if (pos < VEC_BYTES) begin
      hv_word |= 32'(beat.data_byte) << (8 * (pos - 4));
    end
    crc_run = crc32_byte(crc_run, beat.data_byte);
    if (count_run != COUNT_MAX) count_run++;
    verdict = '0;
    if (!beat.is_last) return 1'b0;

    crc_final = crc_run ^ CRC_ONES;
    sat       = (count_run == COUNT_MAX);
    h         = hv_word & ~32'h1;
    // handler bound is taken 33 bits wide so a region near the top cannot wrap
    h_limit   = {1'b0, model_cfg.app_base} + 33'(model_cfg.region_size);
    if (sat || count_run == 0 || 64'(count_run) > 64'(model_cfg.region_size)) begin
      st = ST_BAD_SIZE;
    end else if (count_run < VEC_BYTES || sp_word < model_cfg.sram_base ||
                 sp_word > model_cfg.sram_end) begin
      st = ST_BAD_STACK;          // short images land here too
    end else if (!hv_word[0]) begin
      st = ST_NO_THUMB;
    end else if (h < model_cfg.app_base || {1'b0, h} >= h_limit) begin
      st = ST_BAD_HANDLER;
    end else if (crc_final != model_cfg.expected_crc) begin
      st = ST_BAD_CRC;
    end else begin
      st = ST_OK;
    end
    verdict.image_ok   = (st == ST_OK);
    verdict.status     = st;
    verdict.crc_result = crc_final;
    clear_image_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic dir_row_t row_write(logic [2:0] idx, logic [31:0] wdata);
    dir_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.wdata = wdata;
    r.beat  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t row_beat(logic [7:0] data);
    dir_row_t r;
    r.kind  = ROW_BEAT;
    r.idx   = '0;
    r.wdata = '0;
    r.beat  = {data, 1'b0};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic dir_row_t row_last(logic [7:0] data, out_item_t want);
    dir_row_t r;
    r.kind  = ROW_BEAT;
    r.idx   = '0;
    r.wdata = '0;
    r.beat  = {data, 1'b1};
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Every task is entered after a rising edge or a falling edge that
  // has already had its drive, so each falling edge sees one assignment at most.
  // ---------------------------------------------------------------------------

  // Offer one beat, with an optional idle burst in front of it
  task automatic send_byte(input in_item_t beat, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   verdict;
    gap = 0;
    if (bursts_on && $urandom_range(7, 0) == 0) gap = $urandom_range(12, 1);
    if (gap != 0) begin
      @(negedge clk) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk); while (!in_ready_o);
    bytes_sent++;
    if (image_verdict_step(beat, verdict)) begin
      verdict_q.push_back(typed ? want : verdict);
    end
  endtask

  task automatic send_image();
    in_item_t beat;
    foreach (image_bytes[k]) begin
      beat.data_byte = image_bytes[k];
      beat.is_last   = (k == image_bytes.size() - 1);
      send_byte(beat, 1'b0, '0);
    end
  endtask

  // Drop valid, then hold off until the block has nothing left to say
  task automatic wait_idle();
    @(negedge clk) in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] wdata);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= wdata;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      CFG_EXPECTED_CRC: model_cfg.expected_crc = wdata;
      CFG_REGION_SIZE:  model_cfg.region_size  = wdata[REGION_W-1:0];
      CFG_SRAM_BASE:    model_cfg.sram_base    = wdata;
      CFG_SRAM_END:     model_cfg.sram_end     = wdata;
      CFG_APP_BASE:     model_cfg.app_base     = wdata;
      default: ;        // spare index: nothing changes
    endcase
    @(negedge clk) cfg_valid_i <= 1'b0;
  endtask

  // Register set for the next batch of images; extremes are picked often
  task automatic apply_scenario();
    logic [31:0] base;
    case ($urandom_range(7, 0))
      0: begin
        cfg_write(CFG_REGION_SIZE, 32'(RST_REGION_SIZE));
        cfg_write(CFG_SRAM_BASE, RST_SRAM_BASE);
        cfg_write(CFG_SRAM_END, RST_SRAM_END);
        cfg_write(CFG_APP_BASE, RST_APP_BASE);
      end
      1: begin
        // everything open; upper byte of region write must be dropped
        cfg_write(CFG_SRAM_BASE, 32'h0);
        cfg_write(CFG_SRAM_END, 32'hFFFF_FFFF);
        cfg_write(CFG_APP_BASE, 32'h0);
        cfg_write(CFG_REGION_SIZE, 32'hFFFF_FFFF);
      end
      2: cfg_write(CFG_REGION_SIZE, $urandom_range(40, 8));   // images straddle the limit
      3: cfg_write(CFG_REGION_SIZE, 32'h0);                   // nothing fits
      4: cfg_write(CFG_REGION_SIZE, 32'h1);
      5: begin
        // app region runs past the 4 GiB line
        cfg_write(CFG_APP_BASE, 32'hFFFF_FFFF - $urandom_range(255, 0));
        cfg_write(CFG_REGION_SIZE, $urandom_range(32'h00FF_FFFF, 1024));
      end
      6: begin
        cfg_write(CFG_EXPECTED_CRC, $urandom);
        cfg_write(CFG_REGION_SIZE, $urandom);
        cfg_write(CFG_SRAM_BASE, $urandom);
        cfg_write(CFG_SRAM_END, $urandom);
        cfg_write(CFG_APP_BASE, $urandom);
      end
      default: begin
        // narrow window, may wrap round and end up inverted
        base = $urandom;
        cfg_write(CFG_SRAM_BASE, base);
        cfg_write(CFG_SRAM_END, base + $urandom_range(4095, 0));
      end
    endcase
    if ($urandom_range(3, 0) == 0) begin
      cfg_write(3'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), $urandom);
    end
    if ($urandom_range(3, 0) == 0) cfg_write(CFG_EXPECTED_CRC, $urandom);
  endtask

  // Fills image_bytes; vector words are aimed at the current register set
  task automatic build_image(input img_shape_e shape);
    logic [31:0] sp;
    logic [31:0] hv;
    int unsigned len;
    int unsigned off;
    image_bytes.delete();
    if (model_cfg.sram_base <= model_cfg.sram_end) begin
      case ($urandom_range(5, 0))
        0:       sp = model_cfg.sram_base;
        1:       sp = model_cfg.sram_end;
        default: sp = $urandom_range(model_cfg.sram_end, model_cfg.sram_base);
      endcase
    end else begin
      sp = $urandom;
    end
    if (model_cfg.region_size == 0) begin
      off = 0;
    end else begin
      case ($urandom_range(5, 0))
        0:       off = 0;
        1:       off = model_cfg.region_size - 1;
        default: off = $urandom_range(model_cfg.region_size - 1, 0);
      endcase
    end
    hv  = (model_cfg.app_base + off) | 32'h1;
    len = ($urandom_range(7, 0) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 8);
    case (shape)
      IMG_NO_THUMB:    hv = hv & ~32'h1;
      IMG_BAD_HANDLER: hv = ($urandom_range(1, 0) ? model_cfg.app_base - 32'd2
                            : model_cfg.app_base + model_cfg.region_size) | 32'h1;
      IMG_BAD_STACK:   sp = $urandom_range(1, 0) ? model_cfg.sram_base - 32'd1
                            : model_cfg.sram_end + 32'd1;
      IMG_SHORT:       len = $urandom_range(VEC_BYTES - 1, 1);
      IMG_NOISE:       len = $urandom_range(48, 1);
      default: ;
    endcase
    for (int k = 0; k < len; k++) begin
      if (shape == IMG_SHORT || shape == IMG_NOISE) begin
        image_bytes.push_back(8'($urandom));
      end else if (k < 4) begin
        image_bytes.push_back(sp[8*k +: 8]);
      end else if (k < VEC_BYTES) begin
        image_bytes.push_back(hv[8*(k-4) +: 8]);
      end else begin
        image_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, result side
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: ready low in random bursts while idling is enabled
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall != 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (bursts_on && $urandom_range(5, 0) == 0) begin
        stall = $urandom_range(12, 1) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every verdict beat is matched against the oldest one owed
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("%0t: verdict with none pending: ok=%0b status=%0d crc=%08h", $realtime,
                   out_data_o.image_ok, out_data_o.status, out_data_o.crc_result);
        end
      end else begin
        head_verdict = verdict_q.pop_front();
        if (out_data_o.image_ok !== head_verdict.image_ok ||
            out_data_o.status !== head_verdict.status ||
            out_data_o.crc_result !== head_verdict.crc_result) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: verdict mismatch: exp %0b/%0d/%08h got %0b/%0d/%08h",
                     $realtime, head_verdict.image_ok, head_verdict.status,
                     head_verdict.crc_result, out_data_o.image_ok, out_data_o.status,
                     out_data_o.crc_result);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] crc_acc;
    err_count   = 0;
    cycle_count = 0;
    bytes_sent  = 0;
    bursts_on   = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;

    model_cfg.expected_crc = RST_EXPECTED_CRC;
    model_cfg.region_size  = RST_REGION_SIZE;
    model_cfg.sram_base    = RST_SRAM_BASE;
    model_cfg.sram_end     = RST_SRAM_END;
    model_cfg.app_base     = RST_APP_BASE;
    clear_image_state();

    // Directed table. Single-byte images are short, so they fail on the stack
    // check; "123456789" is the textbook CRC-32 check string, its vector
    // words being 0x34333231 and 0x38373635.
    plan.push_back(row_last(8'h00, {1'b0, ST_BAD_STACK, 32'hD202_EF8D}));
    plan.push_back(row_last(8'hFF, {1'b0, ST_BAD_STACK, 32'hFF00_0000}));
    for (int k = 0; k < 8; k++) plan.push_back(row_beat(8'(8'h31 + k)));
    plan.push_back(row_last(8'h39, {1'b0, ST_BAD_STACK, 32'hCBF4_3926}));
    // zero region: even one byte is oversize
    plan.push_back(row_write(CFG_REGION_SIZE, 32'h0));
    plan.push_back(row_last(8'h00, {1'b0, ST_BAD_SIZE, 32'hD202_EF8D}));
    plan.push_back(row_write(CFG_SPARE_HI, 32'hFFFF_FFFF));
    // every bound set exactly on the check string: size, stack, handler, CRC
    plan.push_back(row_write(CFG_REGION_SIZE, 32'd9));
    plan.push_back(row_write(CFG_SRAM_BASE, 32'h3433_3231));
    plan.push_back(row_write(CFG_SRAM_END, 32'h3433_3231));
    plan.push_back(row_write(CFG_APP_BASE, 32'h3837_3634));
    plan.push_back(row_write(CFG_EXPECTED_CRC, 32'hCBF4_3926));
    for (int k = 0; k < 8; k++) plan.push_back(row_beat(8'(8'h31 + k)));
    plan.push_back(row_last(8'h39, {1'b1, ST_OK, 32'hCBF4_3926}));

    repeat (7) @(posedge clk);
    @(negedge clk) rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(plan[i].idx, plan[i].wdata);
      end else begin
        send_byte(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // Random part: batches of mostly well-formed images, each batch under a
    // fresh register set written while the block is drained
    while (bytes_sent < STREAM_BYTES) begin
      wait_idle();
      bursts_on = (bytes_sent < QUIET_BYTES) && ($urandom_range(3, 0) != 0);
      apply_scenario();
      repeat ($urandom_range(8, 3)) begin
        case ($urandom_range(15, 0))
          9:       build_image(IMG_NO_THUMB);
          10:      build_image(IMG_BAD_HANDLER);
          11:      build_image(IMG_BAD_STACK);
          12, 13:  build_image(IMG_SHORT);
          14, 15:  build_image(IMG_NOISE);
          default: build_image(IMG_GOOD);
        endcase
        send_image();
      end
      // a clean image needs the register to hold its own CRC
      if ($urandom_range(1, 0) == 1) begin
        build_image(IMG_GOOD);
        crc_acc = CRC_ONES;
        foreach (image_bytes[k]) crc_acc = crc32_byte(crc_acc, image_bytes[k]);
        wait_idle();
        cfg_write(CFG_EXPECTED_CRC, crc_acc ^ CRC_ONES);
        send_image();
      end
    end

    bursts_on = 1'b0;
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fiv_pkg.sv
rtl/fiv_crc8.sv
rtl/fiv_check.sv
rtl/firmware_image_verifier.sv
tb/sv/tb_firmware_image_verifier.sv
